>>> src/skew_line_distance_test_core_assert.svh
// assertion macros shared by the checker files
`ifndef SKEW_LINE_DISTANCE_TEST_CORE_ASSERT_SVH
`define SKEW_LINE_DISTANCE_TEST_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define SLD_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define SLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sld_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sld_pkg
// Payload types and fixed datapath widths of the skew line distance test.
// ---------------------------------------------------------------------------
package sld_pkg;

  localparam int COORD_BITS = 16;

  // front end: differences, cross product terms, normal vector
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * COORD_BITS + 2;
  localparam int NVEC_W  = 2 * COORD_BITS + 3;
  localparam int NMAG_W  = 2 * COORD_BITS + 2;
  localparam int CAMAG_W = COORD_BITS + 1;

  // back end: dot product, squared norm, final compare
  localparam int NCA_W  = NMAG_W + CAMAG_W;
  localparam int NSQ_W  = 2 * NMAG_W;
  localparam int DOT_W  = NCA_W + 3;
  localparam int NN_W   = NSQ_W + 2;
  localparam int DMAG_W = DOT_W - 1;
  localparam int LIM_W  = 16;
  localparam int LSQ_W  = 2 * LIM_W;
  localparam int LHS_W  = 2 * DMAG_W;
  localparam int RHS_W  = LSQ_W + NN_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // width of one partial product operand in the wide multipliers
  localparam int LIMB_W = 32;

  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 7;
  localparam int PIPE_STAGES  = FRONT_STAGES + BACK_STAGES;

  localparam logic [LIM_W-1:0] LIMIT_RESET    = 16'd256;
  localparam logic [LSQ_W-1:0] LIMIT_SQ_RESET = 32'd65536;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_y;
    logic signed [COORD_BITS-1:0] d_z;
  } sld_in_t;

  typedef struct packed {
    logic within_limit;
    logic lines_parallel;
  } sld_out_t;

endpackage

>>> src/sld_mul_u.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sld_mul_u
// Two-stage unsigned multiplier: limb partial products, then their sum.
// ---------------------------------------------------------------------------
module sld_mul_u import sld_pkg::*; #(
  parameter int A_W = 32,
  parameter int B_W = 32
) (
  input  logic               clk,
  input  logic [1:0]         adv,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int NA    = (A_W + LIMB_W - 1) / LIMB_W;
  localparam int NB    = (B_W + LIMB_W - 1) / LIMB_W;
  localparam int AP_W  = NA * LIMB_W;
  localparam int BP_W  = NB * LIMB_W;
  localparam int SUM_W = AP_W + BP_W;
  localparam int P_W   = A_W + B_W;

  logic [AP_W-1:0]     a_pad;
  logic [BP_W-1:0]     b_pad;
  logic [2*LIMB_W-1:0] pp_nxt [NA][NB];
  logic [2*LIMB_W-1:0] pp_r   [NA][NB];
  logic [SUM_W-1:0]    acc;
  logic [P_W-1:0]      p_r;

  assign a_pad = AP_W'(a);
  assign b_pad = BP_W'(b);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W])
                     * (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SUM_W'(pp_r[i][j]) << ((i + j) * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pp_r <= pp_nxt;
    end
    if (adv[1]) begin
      p_r <= acc[P_W-1:0];
    end
  end

  assign p = p_r;

endmodule

>>> src/sld_cross.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sld_cross
// Front stages: point differences, cross product n = AB x CD, magnitudes.
// ---------------------------------------------------------------------------
module sld_cross import sld_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] adv,
  input  sld_in_t                 in_data,
  output logic [NMAG_W-1:0]       nmag  [3],
  output logic [CAMAG_W-1:0]      camag [3],
  output logic [2:0]              neg,
  output logic                    par
);

  logic signed [COORD_BITS-1:0] a_pt [3];
  logic signed [COORD_BITS-1:0] b_pt [3];
  logic signed [COORD_BITS-1:0] c_pt [3];
  logic signed [COORD_BITS-1:0] d_pt [3];

  logic signed [DIFF_W-1:0] ab_nxt [3];
  logic signed [DIFF_W-1:0] cd_nxt [3];
  logic signed [DIFF_W-1:0] ca_nxt [3];
  logic signed [DIFF_W-1:0] ab_r   [3];
  logic signed [DIFF_W-1:0] cd_r   [3];
  logic signed [DIFF_W-1:0] ca_r   [3];

  logic signed [PROD_W-1:0] prod_nxt [6];
  logic signed [PROD_W-1:0] prod_r   [6];
  logic signed [DIFF_W-1:0] ca1_r    [3];

  logic signed [NVEC_W-1:0] n_nxt [3];
  logic signed [NVEC_W-1:0] n_r   [3];
  logic signed [DIFF_W-1:0] ca2_r [3];

  logic [NVEC_W-1:0]  n_abs     [3];
  logic [DIFF_W-1:0]  ca_abs    [3];
  logic [NMAG_W-1:0]  nmag_nxt  [3];
  logic [CAMAG_W-1:0] camag_nxt [3];
  logic [2:0]         neg_nxt;
  logic               par_nxt;
  logic [NMAG_W-1:0]  nmag_r    [3];
  logic [CAMAG_W-1:0] camag_r   [3];
  logic [2:0]         neg_r;
  logic               par_r;

  assign a_pt = '{in_data.a_x, in_data.a_y, in_data.a_z};
  assign b_pt = '{in_data.b_x, in_data.b_y, in_data.b_z};
  assign c_pt = '{in_data.c_x, in_data.c_y, in_data.c_z};
  assign d_pt = '{in_data.d_x, in_data.d_y, in_data.d_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab_nxt[k] = DIFF_W'(b_pt[k]) - DIFF_W'(a_pt[k]);
      cd_nxt[k] = DIFF_W'(d_pt[k]) - DIFF_W'(c_pt[k]);
      ca_nxt[k] = DIFF_W'(a_pt[k]) - DIFF_W'(c_pt[k]);
    end
  end

  // cross product terms, one pair per component of n
  always_comb begin
    prod_nxt[0] = PROD_W'(ab_r[1]) * PROD_W'(cd_r[2]);
    prod_nxt[1] = PROD_W'(ab_r[2]) * PROD_W'(cd_r[1]);
    prod_nxt[2] = PROD_W'(ab_r[2]) * PROD_W'(cd_r[0]);
    prod_nxt[3] = PROD_W'(ab_r[0]) * PROD_W'(cd_r[2]);
    prod_nxt[4] = PROD_W'(ab_r[0]) * PROD_W'(cd_r[1]);
    prod_nxt[5] = PROD_W'(ab_r[1]) * PROD_W'(cd_r[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_nxt[k] = NVEC_W'(prod_r[2*k]) - NVEC_W'(prod_r[2*k+1]);
    end
  end

  // sign and magnitude split so the wide multipliers stay unsigned
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_abs[k]     = n_r[k][NVEC_W-1] ? NVEC_W'(-n_r[k]) : NVEC_W'(n_r[k]);
      ca_abs[k]    = ca2_r[k][DIFF_W-1] ? DIFF_W'(-ca2_r[k]) : DIFF_W'(ca2_r[k]);
      nmag_nxt[k]  = n_abs[k][NMAG_W-1:0];
      camag_nxt[k] = ca_abs[k][CAMAG_W-1:0];
      neg_nxt[k]   = n_r[k][NVEC_W-1] ^ ca2_r[k][DIFF_W-1];
    end
    par_nxt = (n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ab_r <= ab_nxt;
      cd_r <= cd_nxt;
      ca_r <= ca_nxt;
    end
    if (adv[1]) begin
      prod_r <= prod_nxt;
      ca1_r  <= ca_r;
    end
    if (adv[2]) begin
      n_r   <= n_nxt;
      ca2_r <= ca1_r;
    end
    if (adv[3]) begin
      nmag_r  <= nmag_nxt;
      camag_r <= camag_nxt;
      neg_r   <= neg_nxt;
      par_r   <= par_nxt;
    end
  end

  assign nmag  = nmag_r;
  assign camag = camag_r;
  assign neg   = neg_r;
  assign par   = par_r;

endmodule

>>> src/sld_dist.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sld_dist
// Back stages: n.CA and |n|^2, squaring, threshold compare, result register.
// ---------------------------------------------------------------------------
module sld_dist import sld_pkg::*; (
  input  logic                   clk,
  input  logic [BACK_STAGES-1:0] adv,
  input  logic [LSQ_W-1:0]       lim_sq,
  input  logic [NMAG_W-1:0]      nmag  [3],
  input  logic [CAMAG_W-1:0]     camag [3],
  input  logic [2:0]             neg,
  input  logic                   par,
  output sld_out_t               out_data
);

  logic [NCA_W-1:0] pnc [3];
  logic [NSQ_W-1:0] pnn [3];

  logic [2:0] neg4_r, neg5_r;
  logic       par4_r, par5_r, par6_r, par7_r, par8_r, par9_r;

  logic [DOT_W-1:0]  term [3];
  logic [DOT_W-1:0]  dot_nxt, dot_r;
  logic [NN_W-1:0]   nn_nxt, nn_r, nn7_r;
  logic [DOT_W-1:0]  dot_abs;
  logic [DMAG_W-1:0] dmag_r;

  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;
  sld_out_t         out_nxt, out_r;

  for (genvar k = 0; k < 3; k++) begin : g_vec
    sld_mul_u #(.A_W(NMAG_W), .B_W(CAMAG_W)) u_mul_nca (
      .clk (clk),
      .adv (adv[1:0]),
      .a   (nmag[k]),
      .b   (camag[k]),
      .p   (pnc[k])
    );
    sld_mul_u #(.A_W(NMAG_W), .B_W(NMAG_W)) u_mul_nn (
      .clk (clk),
      .adv (adv[1:0]),
      .a   (nmag[k]),
      .b   (nmag[k]),
      .p   (pnn[k])
    );
  end

  always_comb begin
    dot_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      term[k] = neg5_r[k] ? DOT_W'(-DOT_W'(pnc[k])) : DOT_W'(pnc[k]);
      dot_nxt = dot_nxt + term[k];
    end
    nn_nxt = NN_W'(pnn[0]) + NN_W'(pnn[1]) + NN_W'(pnn[2]);
  end

  assign dot_abs = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : dot_r;

  sld_mul_u #(.A_W(DMAG_W), .B_W(DMAG_W)) u_mul_lhs (
    .clk (clk),
    .adv (adv[5:4]),
    .a   (dmag_r),
    .b   (dmag_r),
    .p   (lhs)
  );

  sld_mul_u #(.A_W(LSQ_W), .B_W(NN_W)) u_mul_rhs (
    .clk (clk),
    .adv (adv[5:4]),
    .a   (lim_sq),
    .b   (nn7_r),
    .p   (rhs)
  );

  // parallel lines have n = 0, the compare alone would already fail
  always_comb begin
    out_nxt.lines_parallel = par9_r;
    out_nxt.within_limit   = !par9_r && (CMP_W'(lhs) < CMP_W'(rhs));
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg4_r <= neg;
      par4_r <= par;
    end
    if (adv[1]) begin
      neg5_r <= neg4_r;
      par5_r <= par4_r;
    end
    if (adv[2]) begin
      dot_r  <= dot_nxt;
      nn_r   <= nn_nxt;
      par6_r <= par5_r;
    end
    if (adv[3]) begin
      dmag_r <= dot_abs[DMAG_W-1:0];
      nn7_r  <= nn_r;
      par7_r <= par6_r;
    end
    if (adv[4]) begin
      par8_r <= par7_r;
    end
    if (adv[5]) begin
      par9_r <= par8_r;
    end
    if (adv[6]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

>>> src/skew_line_distance_test_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skew_line_distance_test_core
// Tests whether the distance between two 3D lines is below a set limit.
// ---------------------------------------------------------------------------
// One line pair (A,B and C,D in signed Q8.8) is taken per clock unless a stall
// backs up to the input. Its result passes through the depth of the pipeline:
// four front stages for differences and the cross product n = AB x CD, two
// for n.CA and |n|^2, two to combine and take magnitudes, two for the squaring
// multipliers and one result register.
// The test is (n.CA)^2 < limit^2 * |n|^2 in exact integer arithmetic, so
// within_limit is strictly-below and is 0 for parallel or degenerate lines,
// which also raise lines_parallel. distance_limit (unsigned Q8.8, reset 1.0)
// is written through the cfg port and must only change while the pipeline is
// empty. Stalls back up stage by stage, so no item is dropped or repeated.
module skew_line_distance_test_core import sld_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sld_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sld_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LIM_W-1:0] cfg_data
);

  logic [LIM_W-1:0]       limit_r, limit_nxt;
  logic [LSQ_W-1:0]       lim_sq_r, lim_sq_nxt;
  logic [PIPE_STAGES-1:0] valid_r, valid_nxt;
  logic [PIPE_STAGES-1:0] adv;

  logic [NMAG_W-1:0]  nmag  [3];
  logic [CAMAG_W-1:0] camag [3];
  logic [2:0]         neg;
  logic               par;

  assign cfg_ready  = 1'b1;
  assign limit_nxt  = (cfg_valid && cfg_ready) ? cfg_data : limit_r;
  assign lim_sq_nxt = LSQ_W'(limit_r) * LSQ_W'(limit_r);

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[PIPE_STAGES-1] = !valid_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
    valid_nxt[0] = adv[0] ? in_valid : valid_r[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      valid_nxt[k] = adv[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      lim_sq_r <= LIMIT_SQ_RESET;
      valid_r  <= '0;
    end else begin
      limit_r  <= limit_nxt;
      lim_sq_r <= lim_sq_nxt;
      valid_r  <= valid_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = valid_r[PIPE_STAGES-1];

  sld_cross u_cross (
    .clk     (clk),
    .adv     (adv[FRONT_STAGES-1:0]),
    .in_data (in_data),
    .nmag    (nmag),
    .camag   (camag),
    .neg     (neg),
    .par     (par)
  );

  sld_dist u_dist (
    .clk      (clk),
    .adv      (adv[PIPE_STAGES-1:FRONT_STAGES]),
    .lim_sq   (lim_sq_r),
    .nmag     (nmag),
    .camag    (camag),
    .neg      (neg),
    .par      (par),
    .out_data (out_data)
  );

endmodule

>>> src/sld_port_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sld_port_check
// Port-level checks of the skew line distance test core, bound to the top.
// ---------------------------------------------------------------------------
`include "skew_line_distance_test_core_assert.svh"

module sld_port_check import sld_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sld_out_t out_data,
  input logic     cfg_valid,
  input logic     cfg_ready
);

  // a waiting result holds until its transfer
  `SLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // n = 0 can never pass the strict compare
  `SLD_ASSERT_HOLDS(a_flag_excl, clk, rst_n, out_valid, !(out_data.within_limit && out_data.lines_parallel), "parallel lines reported within limit")

  // input backs up only when every stage is full and the output is stalled
  `SLD_ASSERT_HOLDS(a_stall_full, clk, rst_n, in_valid && in_stall, out_valid && out_stall, "input stalled with room in pipeline")

  // register port never refuses a write
  `SLD_ASSERT_HOLDS(a_cfg_take, clk, rst_n, cfg_valid, cfg_ready, "config write refused")

endmodule

bind skew_line_distance_test_core sld_port_check u_port_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
